// File: hw/rtl/spq_pkg.sv
// Shared types, constants and helper functions of the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W     = 31;
    localparam int PRIO_W      = 16;
    localparam int OCC_W       = 5;
    localparam int ENTRY_W     = VALUE_W + PRIO_W;

    typedef enum logic [0:0] {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        func_t               func;
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   priority_req;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [VALUE_W-1:0]  out_value;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    // Next slot of the circular store, wrapping at the queue depth.
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(QUEUE_DEPTH - 1))
            nxt = '0;
        else
            nxt = idx + 1'b1;
        return nxt;
    endfunction

    // Entry count reported modulo 32.
    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[OCC_W-1:0];
    endfunction

endpackage

// File: hw/rtl/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/spq_seq.sv
// Sequencer that walks the entry store with one shared priority comparator.
module spq_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  spq_pkg::req_t req,
    output logic          req_stall,
    output logic          res_valid,
    output spq_pkg::rsp_t res,
    input  logic          res_stall
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_DEQ,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] left_reg, left_next;
    entry_t           carry_reg, carry_next;
    rsp_t             res_reg, res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    entry_t           ram_rdata;
    logic             take;
    logic             stored_gt;

    spq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign take      = req_valid && (state_reg == S_IDLE);
    // The one comparator: stored entry strictly behind the carried one.
    assign stored_gt = ram_rdata.prio > carry_reg.prio;

    // During the walk the next slot is fetched while the current one is compared.
    assign ram_raddr = (state_reg == S_WALK) ? slot_inc(cur_reg) : head_reg;
    assign ram_waddr = cur_reg;
    assign ram_wdata = carry_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        left_next  = left_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (req.func == FUNC_ENQ)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            res_next   = '{status: ST_FULL, out_value: '0,
                                           occupancy: to_occ(count_reg)};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            carry_next = '{value: req.value, prio: req.priority_req};
                            cur_next   = head_reg;
                            left_next  = count_reg;
                            state_next = (count_reg == '0) ? S_TAIL : S_WALK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = '{status: ST_EMPTY, out_value: '0,
                                           occupancy: to_occ(count_reg)};
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DEQ;
                        end
                    end
                end
            end
            S_WALK:
            begin
                if (stored_gt)
                begin
                    ram_we     = 1'b1;
                    carry_next = ram_rdata;
                end
                cur_next  = slot_inc(cur_reg);
                left_next = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
                res_next   = '{status: ST_ENQUEUED, out_value: '0,
                               occupancy: to_occ(CNT_W'(count_reg + 1'b1))};
                state_next = S_DONE;
            end
            S_DEQ:
            begin
                head_next  = slot_inc(head_reg);
                count_next = count_reg - 1'b1;
                res_next   = '{status: ST_DEQUEUED, out_value: ram_rdata.value,
                               occupancy: to_occ(CNT_W'(count_reg - 1'b1))};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= '0;
            left_reg  <= '0;
            carry_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            left_reg  <= left_next;
            carry_reg <= carry_next;
            res_reg   <= res_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= IDX_W'(QUEUE_DEPTH - 1))
        else $error("head slot outside the store");

    a_walk_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ram_raddr != ram_waddr))
        else $error("walk reads the slot it writes");

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && left_reg == CNT_W'(1)) |=> (state_reg == S_TAIL))
        else $error("walk did not end at the tail");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("store written outside an operation");
`endif

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: sequencer plus result register.
//
//   Channel   Valid       Stall       Payload  Carries
//   request   req_valid   req_stall   req      func, value, priority_req
//   result    rsp_valid   rsp_stall   rsp      status, out_value, occupancy
//
// An enqueue takes the request, walks the store from head to tail with
// the single priority comparator, writes the tail slot and hands the
// result to the output register. A dequeue takes the request, reads the
// head slot and hands the result on; a dequeue from an empty queue or an
// enqueue into a full one hands its status on right after the request.
// Reset (rst_n, asynchronous, active low) empties the queue; the store
// itself is never cleared, since only written slots are ever used.
// A stalled result sits in the output register while the sequencer already
// takes the next request; the sequencer waits only when it finishes a
// second result before the first one has left.
module sorted_priority_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    logic res_valid;
    logic res_stall;
    logic res_take;
    rsp_t res;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    // The sequencer owns the store, the head and count, and the comparator.
    spq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req      (req),
        .req_stall(req_stall),
        .res_valid(res_valid),
        .res      (res),
        .res_stall(res_stall)
    );

    // The output register is free when empty or when its result leaves now.
    assign res_stall = rsp_valid_reg && rsp_stall;
    assign res_take  = res_valid && !res_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
